// ----- sv/cmt_pkg.sv -----
// shared types and constants for the counting multiset table
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package cmt_pkg;

   localparam int MODE_W    = 2;
   localparam int REQ_KEY_W = 16;
   localparam int AMT_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 16;
   localparam int USED_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } cmt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_blocked;
   } cmt_sts_type;

endpackage

`default_nettype wire

// ----- sv/cmt_ctrl.sv -----
// two-state sequencer: take a transaction, then commit it into the table
// depends on cmt_pkg
`default_nettype none

module cmt_ctrl import cmt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire cmt_sts_type sts,
   output cmt_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // hold here while the previous result is still waiting
            if (!sts.rsp_blocked) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cmt_datapath.sv -----
// table cells with parallel key compare, count update, ordered delete
// shift and the result register; depends on cmt_pkg
`default_nettype none

module cmt_datapath import cmt_pkg::*; #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmt_cmd_type          cmd,
   output cmt_sts_type               sts,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [REQ_KEY_W-1:0] req_key,
   input  wire logic [AMT_W-1:0]     req_amount,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic [USED_W-1:0]         rsp_used_entries
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // table cells
   logic [KEY_BITS-1:0] key_ff [DEPTH];
   logic [COUNT_W-1:0]  cnt_ff [DEPTH];
   logic [CNT_W-1:0]    total_ff, total_in;

   // captured transaction
   logic [KEY_BITS-1:0] key_x;
   logic [KEY_BITS-1:0] rkey_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [AMT_W-1:0]    amt_ff;
   logic [DEPTH-1:0]    match_ff, match_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [USED_W-1:0]   used_ff;

   // update decisions
   logic [COUNT_W-1:0]  cur_cnt;
   logic [COUNT_W-1:0]  new_cnt;
   logic [COUNT_W:0]    sum;
   logic [DEPTH-1:0]    at_or_after;
   logic                hit;
   logic                do_set;
   logic                do_append;
   logic                do_delete;

   // key bits above KEY_BITS do not take part
   for (genvar b = 0; b < KEY_BITS; b++) begin : g_key
      if (b < REQ_KEY_W) begin : g_bit
         assign key_x[b] = req_key[b];
      end else begin : g_zero
         assign key_x[b] = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < total_ff) && (key_ff[i] == key_x);
      end
   end

   always_comb begin
      logic run;
      run     = 1'b0;
      cur_cnt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_ff[i]) begin
            cur_cnt = cur_cnt | cnt_ff[i];
         end
         run            = run | match_ff[i];
         at_or_after[i] = run;
      end
   end

   always_comb begin
      hit       = |match_ff;
      sum       = {1'b0, cur_cnt} + (COUNT_W + 1)'(amt_ff);
      new_cnt   = cur_cnt;
      do_set    = 1'b0;
      do_append = 1'b0;
      do_delete = 1'b0;
      status_in = STATUS_OK;
      count_in  = '0;
      total_in  = total_ff;
      case (mode_ff)
         MODE_ADD: begin
            if (hit) begin
               do_set = 1'b1;
               if (sum[COUNT_W]) begin
                  new_cnt   = COUNT_MAX;
                  status_in = STATUS_SAT;
               end else begin
                  new_cnt = sum[COUNT_W-1:0];
               end
               count_in = new_cnt;
            end else if (amt_ff == '0) begin
               status_in = STATUS_OK;
            end else if (total_ff < CNT_W'(DEPTH)) begin
               do_append = 1'b1;
               count_in  = COUNT_W'(amt_ff);
               total_in  = total_ff + CNT_W'(1);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_REMOVE: begin
            if (!hit) begin
               status_in = STATUS_MISS;
            end else if (cur_cnt > COUNT_W'(1)) begin
               do_set   = 1'b1;
               new_cnt  = cur_cnt - COUNT_W'(1);
               count_in = new_cnt;
            end else begin
               do_delete = 1'b1;
               total_in  = total_ff - CNT_W'(1);
            end
         end
         default: begin
            // search, and the unused fourth code
            if (hit) begin
               count_in = cur_cnt;
            end else begin
               status_in = STATUS_MISS;
            end
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] up_key;
      logic [COUNT_W-1:0]  up_cnt;

      if (i < DEPTH - 1) begin : g_up
         assign up_key = key_ff[i+1];
         assign up_cnt = cnt_ff[i+1];
      end else begin : g_top
         assign up_key = key_ff[i];
         assign up_cnt = cnt_ff[i];
      end

      always_ff @(posedge clock) begin
         if (cmd.commit) begin
            if (do_set && match_ff[i]) begin
               cnt_ff[i] <= new_cnt;
            end else if (do_append && (CNT_W'(i) == total_ff)) begin
               key_ff[i] <= rkey_ff;
               cnt_ff[i] <= COUNT_W'(amt_ff);
            end else if (do_delete && at_or_after[i]) begin
               // close the gap, later entries move down one place
               key_ff[i] <= up_key;
               cnt_ff[i] <= up_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rkey_ff  <= key_x;
         mode_ff  <= req_mode;
         amt_ff   <= req_amount;
         match_ff <= match_in;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         count_ff  <= count_in;
         used_ff   <= USED_W'(32'(total_in));
      end
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            total_ff <= total_in;
         end
      end
   end

   assign sts.rsp_blocked  = rsp_valid_ff && rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_count        = count_ff;
   assign rsp_used_entries = used_ff;

`ifndef ASSERT_OFF
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(DEPTH))
      else $error("entry total beyond table depth");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(match_ff))
      else $error("key found in more than one used entry");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> total_ff == $past(total_ff))
      else $error("entry total moved without a commit");
`endif

endmodule

`default_nettype wire

// ----- sv/counting_multiset_table_core.sv -----
// Counting multiset table: ordered table of distinct keys with occurrence counts.
// Request channel (req_valid/req_stall) carries mode, key and amount; mode add
// adds amount to the key's count (saturating at 65535) or appends the key when
// absent with a nonzero amount and room left, remove takes one occurrence away
// and deletes the entry at the last one with later entries moving down, search
// reports the count. Every transaction gives one response (rsp_valid/rsp_stall)
// carrying status, count and the number of used entries.
// Timing: a request is compared against all cells when accepted and committed
// from ST_APPLY once no stalled response blocks it, loading the response register.
// A new request is taken only after the previous one has committed.
// The response is registered, so the next request is taken while a response
// waits; a stalled response holds its value and the following commit waits
// until it is taken, holding req_stall high meanwhile.
// Reset (synchronous, active high) empties the table and drops any pending
// response; no clearing pass is needed.
// depends on cmt_pkg, cmt_ctrl, cmt_datapath
`default_nettype none

module counting_multiset_table_core import cmt_pkg::*; #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [REQ_KEY_W-1:0] req_key,
   input  wire logic [AMT_W-1:0]     req_amount,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic [USED_W-1:0]         rsp_used_entries
);

   cmt_cmd_type cmd;
   cmt_sts_type sts;

   cmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cmt_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_used_entries (rsp_used_entries)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_counting_multiset_table_core.sv -----
// self-checking testbench for counting_multiset_table_core
// depends on cmt_pkg and the core; holds its own copy of the key/count table
`timescale 1ns / 100ps

module tb_counting_multiset_table_core;
   import cmt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_WIDTH   = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;
   localparam int HOLD_CYCLES = 250;
   localparam int POOL_SIZE   = 24;

   // the fourth mode code has no name in the package; the core treats it as a search
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [REQ_KEY_W-1:0] key;
      logic [AMT_W-1:0]     amount;
   } bag_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [USED_W-1:0]   used;
   } bag_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode   = '0;
   logic [REQ_KEY_W-1:0] req_key    = '0;
   logic [AMT_W-1:0]     req_amount = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_count;
   logic [USED_W-1:0]    rsp_used_entries;

   counting_multiset_table_core #(
      .DEPTH    (TABLE_DEPTH),
      .KEY_BITS (KEY_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_used_entries (rsp_used_entries)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the table
   logic [REQ_KEY_W-1:0] bag_keys   [TABLE_DEPTH];
   logic [COUNT_W-1:0]   bag_counts [TABLE_DEPTH];
   int                   bag_used = 0;

   bag_op_type    op_backlog[$];
   bag_reply_type expected_replies[$];

   int errors = 0;
   int cycle_n = 0;
   int accepted_n = 0;
   int replies_n = 0;
   int planned_n = 0;
   int adds_n = 0, removes_n = 0, searches_n = 0;
   int saturated_n = 0, full_n = 0, deleted_n = 0, missed_n = 0, peak_used = 0;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // update the shadow table for one transaction and queue the reply it must give
   function automatic void apply_bag_op(bag_op_type op);
      int            idx;
      bit            hit;
      int unsigned   total;
      bag_reply_type r;
      idx = bag_used;
      hit = 1'b0;
      for (int i = 0; i < bag_used; i++) begin
         if (!hit && bag_keys[i] == op.key) begin
            idx = i;
            hit = 1'b1;
         end
      end
      r.status = STATUS_OK;
      r.count  = '0;
      case (op.mode)
         MODE_ADD: begin
            adds_n++;
            if (hit) begin
               total = 32'(bag_counts[idx]) + 32'(op.amount);
               if (total > 32'(COUNT_MAX)) begin
                  total = 32'(COUNT_MAX);
                  r.status = STATUS_SAT;
                  saturated_n++;
               end
               bag_counts[idx] = COUNT_W'(total);
               r.count = COUNT_W'(total);
            end else if (op.amount == 0) begin
               r.status = STATUS_OK;
            end else if (bag_used < TABLE_DEPTH) begin
               bag_keys[bag_used]   = op.key;
               bag_counts[bag_used] = COUNT_W'(op.amount);
               bag_used++;
               r.count = COUNT_W'(op.amount);
            end else begin
               r.status = STATUS_FULL;
               full_n++;
            end
         end
         MODE_REMOVE: begin
            removes_n++;
            if (!hit) begin
               r.status = STATUS_MISS;
               missed_n++;
            end else if (bag_counts[idx] > 1) begin
               bag_counts[idx] = bag_counts[idx] - 1'b1;
               r.count = bag_counts[idx];
            end else begin
               // last occurrence: close the gap, keeping insertion order
               for (int i = idx; i + 1 < bag_used; i++) begin
                  bag_keys[i]   = bag_keys[i + 1];
                  bag_counts[i] = bag_counts[i + 1];
               end
               bag_used--;
               deleted_n++;
            end
         end
         default: begin
            searches_n++;
            if (hit) r.count = bag_counts[idx];
            else begin
               r.status = STATUS_MISS;
               missed_n++;
            end
         end
      endcase
      r.used = USED_W'(bag_used);
      if (bag_used > peak_used) peak_used = bag_used;
      expected_replies = {expected_replies, r};
   endfunction

   task automatic push_op(input logic [MODE_W-1:0] mode, input logic [REQ_KEY_W-1:0] key,
                          input logic [AMT_W-1:0] amount);
      bag_op_type op;
      op.mode   = mode;
      op.key    = key;
      op.amount = amount;
      op_backlog = {op_backlog, op};
   endtask

   // request driver
   int gap_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin : request_driver
      bag_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            nxt.mode   = req_mode;
            nxt.key    = req_key;
            nxt.amount = req_amount;
            apply_bag_op(nxt);
            accepted_n++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (op_backlog.size() > 0) begin
               nxt = op_backlog.pop_front();
               req_valid  <= 1'b1;
               req_mode   <= nxt.mode;
               req_key    <= nxt.key;
               req_amount <= nxt.amount;
               // occasional stretch with back-to-back transactions
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
                  gap_left   <= 0;
               end else begin
                  if ($urandom_range(0, 99) < 3) burst_left <= 30;
                  gap_left <= idle_length();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall generator, with one long hold-off to back the core up
   int  stall_left = 0;
   int  flow_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         flow_left  <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!hold_done && accepted_n >= 120) begin
         hold_done  <= 1'b1;
         rsp_stall  <= 1'b1;
         stall_left <= HOLD_CYCLES;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left <= flow_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= idle_length();
         flow_left  <= ($urandom_range(0, 99) < 5) ? 40 : $urandom_range(0, 6);
      end
   end

   // response monitor
   always @(posedge clock) begin : reply_monitor
      bag_reply_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_n++;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected transaction: status %0d count %0d used %0d",
                     $time, rsp_status, rsp_count, rsp_used_entries);
            errors++;
         end else begin
            exp_r = expected_replies.pop_front();
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, exp_r.status, rsp_status);
               errors++;
            end
            if (rsp_count !== exp_r.count) begin
               $display("%0t: count mismatch: expected %0d, got %0d",
                        $time, exp_r.count, rsp_count);
               errors++;
            end
            if (rsp_used_entries !== exp_r.used) begin
               $display("%0t: used entries mismatch: expected %0d, got %0d",
                        $time, exp_r.used, rsp_used_entries);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d replies still outstanding", $time,
                  expected_replies.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [REQ_KEY_W-1:0] key_pool[POOL_SIZE];
      logic [MODE_W-1:0]    m;
      logic [REQ_KEY_W-1:0] k;
      logic [AMT_W-1:0]     a;
      int                   r;
      int                   add_pct;

      // directed: empty-table misses, zero add, delete from the middle, spare mode,
      // filling the table and adding to it when full
      push_op(MODE_SEARCH, 16'h0000, 8'h00);
      push_op(MODE_REMOVE, 16'h0000, 8'hff);
      push_op(MODE_ADD,    16'h0000, 8'h00);
      push_op(MODE_ADD,    16'h0000, 8'hff);
      push_op(MODE_ADD,    16'hffff, 8'h01);
      push_op(MODE_ADD,    16'h5a5a, 8'h02);
      push_op(MODE_ADD,    16'ha5a5, 8'h01);
      push_op(MODE_REMOVE, 16'hffff, 8'h00);
      push_op(MODE_SEARCH, 16'ha5a5, 8'haa);
      push_op(MODE_REMOVE, 16'h5a5a, 8'h55);
      push_op(MODE_SPARE,  16'h0000, 8'hff);
      for (int i = 0; i < 13; i++) begin
         push_op(MODE_ADD, REQ_KEY_W'(16'h1000 + i), AMT_W'(i + 1));
      end
      push_op(MODE_ADD,    16'h7777, 8'h09);
      push_op(MODE_ADD,    16'h7778, 8'h00);

      // pump one key past the count ceiling, poking it now and then
      for (int i = 0; i < 262; i++) begin
         push_op(MODE_ADD, 16'h0000, AMT_W'($urandom_range(252, 255)));
         if (i % 40 == 39) begin
            push_op(MODE_SEARCH, 16'h0000, AMT_W'($urandom_range(0, 255)));
            push_op(MODE_REMOVE, 16'h0000, AMT_W'($urandom_range(0, 255)));
         end
      end
      push_op(MODE_ADD, 16'h0000, 8'hff);

      // random mix over a small key pool; add-heavy half, then a half with adds and removes equally likely
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hffff;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = REQ_KEY_W'($urandom_range(0, 65535));
      for (int i = 0; i < 340; i++) begin
         add_pct = (i < 170) ? 55 : 30;
         r = $urandom_range(0, 99);
         if (r < add_pct) m = MODE_ADD;
         else if (r < add_pct + 30) m = MODE_REMOVE;
         else if (r < 95) m = MODE_SEARCH;
         else m = MODE_SPARE;
         if ($urandom_range(0, 99) < 90) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else k = REQ_KEY_W'($urandom_range(0, 65535));
         r = $urandom_range(0, 99);
         if (m != MODE_ADD || r >= 80) a = AMT_W'($urandom_range(0, 255));
         else if (r < 70) a = AMT_W'($urandom_range(1, 3));
         else a = '0;
         push_op(m, k, a);
      end
      planned_n = op_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every queued transaction has to come back before the run ends
      while (replies_n < planned_n) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d transactions: %0d adds, %0d removes, %0d searches",
               replies_n, adds_n, removes_n, searches_n);
      $display("saturated %0d, table full %0d, entries deleted %0d, misses %0d, peak %0d entries",
               saturated_n, full_n, deleted_n, missed_n, peak_used);
      if (errors == 0 && accepted_n == planned_n && expected_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- counting_multiset_table_core.f -----
sv/cmt_pkg.sv
sv/cmt_ctrl.sv
sv/cmt_datapath.sv
sv/counting_multiset_table_core.sv
tb/sv/tb_counting_multiset_table_core.sv
